FILE: design/rpi_pkg.sv
// shared types and constants of the ring position interpolator
`timescale 1ns / 1ps

package rpi_pkg;

  localparam int unsigned BT_BITS       = 32;
  localparam int unsigned CFG_IDX_BITS  = 2;
  localparam int unsigned CFG_DATA_BITS = 32;

  localparam logic [CFG_IDX_BITS-1:0] REG_BUFFER_TIME   = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_BUFFER_FRAMES = 2'd1;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_STOP  = 2'd1,
    CMD_STAMP = 2'd2,
    CMD_QUERY = 2'd3
  } cmd_e;

  typedef struct packed {
    logic load_stamp;
    logic clr_floor;
    logic load_elapsed;
    logic setup;
    logic step;
    logic mul;
    logic load_div;
    logic finish;
    logic pend_zero;
    logic pend_flag;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic now_lt_last;
    logic bt_zero;
    logic div_done;
  } dp_sts_t;

endpackage

FILE: design/rpi_if.sv
// handshake channel interfaces of the ring position interpolator
`timescale 1ns / 1ps

interface rpi_in_if #(
  parameter int unsigned TIME_BITS = 63
);
  logic                 valid;
  logic                 ready;
  logic [1:0]           cmd;
  logic [TIME_BITS-1:0] time_ns;

  modport source (output valid, output cmd, output time_ns, input ready);
  modport sink   (input valid, input cmd, input time_ns, output ready);
endinterface

interface rpi_out_if #(
  parameter int unsigned FRAME_BITS = 20
);
  logic                  valid;
  logic                  ready;
  logic [FRAME_BITS-1:0] position_frames;
  logic                  period_elapsed;

  modport source (output valid, output position_frames, output period_elapsed, input ready);
  modport sink   (input valid, input position_frames, input period_elapsed, output ready);
endinterface

interface rpi_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [rpi_pkg::CFG_IDX_BITS-1:0]  index;
  logic [rpi_pkg::CFG_DATA_BITS-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: design/rpi_ctrl.sv
// controller state machine of the ring position interpolator
`timescale 1ns / 1ps

module rpi_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [1:0]       in_cmd_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  rpi_pkg::dp_sts_t sts_i,
  output rpi_pkg::dp_cmd_t cmd_o
);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_SETUP = 7'b0000010,
    ST_MOD   = 7'b0000100,
    ST_DIVL  = 7'b0001000,
    ST_DIV   = 7'b0010000,
    ST_FIN   = 7'b0100000,
    ST_SPARE = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic   running_q, running_d;
  logic   awaiting_q, awaiting_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;
  logic   out_free;
  rpi_pkg::cmd_e in_cmd;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign in_cmd      = rpi_pkg::cmd_e'(in_cmd_i);

  always_comb begin
    state_d     = state_q;
    running_d   = running_q;
    awaiting_d  = awaiting_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_FIN;
          unique case (in_cmd)
            rpi_pkg::CMD_START: begin
              running_d       = 1'b1;
              awaiting_d      = 1'b1;
              cmd_o.clr_floor = 1'b1;
              cmd_o.pend_zero = 1'b1;
            end
            rpi_pkg::CMD_STOP: begin
              running_d       = 1'b0;
              cmd_o.pend_zero = 1'b1;
            end
            rpi_pkg::CMD_STAMP: begin
              awaiting_d       = 1'b0;
              cmd_o.load_stamp = 1'b1;
              cmd_o.pend_zero  = 1'b1;
              cmd_o.pend_flag  = !awaiting_q;
            end
            rpi_pkg::CMD_QUERY: begin
              if (!running_q || awaiting_q || sts_i.now_lt_last || sts_i.bt_zero) begin
                cmd_o.pend_zero = 1'b1;
              end else begin
                cmd_o.load_elapsed = 1'b1;
                state_d            = ST_SETUP;
              end
            end
            default: begin
              cmd_o.pend_zero = 1'b1;
            end
          endcase
        end
      end
      ST_SETUP: begin
        cmd_o.setup = 1'b1;
        state_d     = ST_MOD;
      end
      ST_MOD: begin
        if (sts_i.div_done) begin
          cmd_o.mul = 1'b1;
          state_d   = ST_DIVL;
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      ST_DIVL: begin
        cmd_o.load_div = 1'b1;
        state_d        = ST_DIV;
      end
      ST_DIV: begin
        if (sts_i.div_done) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_FIN;
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      running_q   <= 1'b0;
      awaiting_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      running_q   <= running_d;
      awaiting_q  <= awaiting_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

FILE: design/rpi_datapath.sv
// datapath of the ring position interpolator: stamp, floor, shared divider, multiplier
`timescale 1ns / 1ps

module rpi_datapath #(
  parameter int unsigned TIME_BITS  = 63,
  parameter int unsigned FRAME_BITS = 20
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  rpi_pkg::dp_cmd_t                  cmd_i,
  output rpi_pkg::dp_sts_t                  sts_o,
  input  logic [TIME_BITS-1:0]              time_i,
  input  logic                              cfg_we_i,
  input  logic [rpi_pkg::CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [rpi_pkg::CFG_DATA_BITS-1:0] cfg_data_i,
  output logic [FRAME_BITS-1:0]             position_o,
  output logic                              period_o
);

  localparam int unsigned BT_BITS   = rpi_pkg::BT_BITS;
  localparam int unsigned PROD_BITS = BT_BITS + FRAME_BITS;
  localparam int unsigned DIV_BITS  = (TIME_BITS > PROD_BITS) ? TIME_BITS : PROD_BITS;
  localparam int unsigned CNT_BITS  = $clog2(DIV_BITS + 1);

  logic [BT_BITS-1:0]    bt_q;
  logic [FRAME_BITS-1:0] frames_q;
  logic [TIME_BITS-1:0]  last_q;
  logic [FRAME_BITS-1:0] floor_q;
  logic [DIV_BITS-1:0]   dvd_q;
  logic [BT_BITS-1:0]    rem_q;
  logic [FRAME_BITS-1:0] quot_q;
  logic [CNT_BITS-1:0]   cnt_q;
  logic [PROD_BITS-1:0]  prod_q;
  logic                  lt1_q, lt2_q;
  logic [FRAME_BITS-1:0] pend_pos_q, pos_q;
  logic                  pend_flag_q, flag_q;

  logic [TIME_BITS-1:0] elapsed;
  logic [BT_BITS:0]     part;
  logic [BT_BITS:0]     diff;
  logic                 ge;
  logic [BT_BITS-1:0]   rem_d;

  assign elapsed = time_i - last_q;
  assign part    = {rem_q, dvd_q[DIV_BITS-1]};
  assign diff    = part - {1'b0, bt_q};
  assign ge      = (part >= {1'b0, bt_q});
  assign rem_d   = ge ? diff[BT_BITS-1:0] : part[BT_BITS-1:0];

  assign sts_o.now_lt_last = (time_i < last_q);
  assign sts_o.bt_zero     = (bt_q == '0);
  assign sts_o.div_done    = (cnt_q == '0);

  assign position_o = pos_q;
  assign period_o   = flag_q;

  // configuration and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bt_q     <= BT_BITS'(1);
      frames_q <= FRAME_BITS'(1);
      last_q   <= '0;
      floor_q  <= '0;
    end else begin
      if (cfg_we_i && (cfg_idx_i == rpi_pkg::REG_BUFFER_TIME)) begin
        bt_q <= cfg_data_i[BT_BITS-1:0];
      end
      if (cfg_we_i && (cfg_idx_i == rpi_pkg::REG_BUFFER_FRAMES)) begin
        frames_q <= cfg_data_i[FRAME_BITS-1:0];
      end
      if (cmd_i.load_stamp) begin
        last_q <= time_i;
      end
      if (cmd_i.clr_floor) begin
        floor_q <= '0;
      end else if (cmd_i.finish) begin
        if (lt1_q) begin
          if (quot_q >= floor_q) begin
            floor_q <= '0;
          end
        end else if (lt2_q) begin
          floor_q <= quot_q;
        end else begin
          floor_q <= '0;
        end
      end
    end
  end

  // restoring divider, one quotient bit per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.setup || cmd_i.load_div) begin
      cnt_q <= CNT_BITS'(DIV_BITS);
    end else if (cmd_i.step) begin
      cnt_q <= cnt_q - CNT_BITS'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_elapsed) begin
      dvd_q <= DIV_BITS'(elapsed);
    end else if (cmd_i.load_div) begin
      dvd_q <= DIV_BITS'(prod_q);
    end else if (cmd_i.step) begin
      dvd_q <= {dvd_q[DIV_BITS-2:0], 1'b0};
    end
    if (cmd_i.setup || cmd_i.load_div) begin
      rem_q  <= '0;
      quot_q <= '0;
    end else if (cmd_i.step) begin
      rem_q  <= rem_d;
      quot_q <= {quot_q[FRAME_BITS-2:0], ge};
    end
    if (cmd_i.setup) begin
      lt1_q <= (dvd_q[TIME_BITS-1:0] < TIME_BITS'(bt_q));
      lt2_q <= ({1'b0, dvd_q[TIME_BITS-1:0]} < (TIME_BITS + 1)'({bt_q, 1'b0}));
    end
    if (cmd_i.mul) begin
      prod_q <= PROD_BITS'(rem_q) * PROD_BITS'(frames_q);
    end
  end

  // pending result and output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.pend_zero) begin
      pend_pos_q  <= '0;
      pend_flag_q <= cmd_i.pend_flag;
    end else if (cmd_i.finish) begin
      pend_flag_q <= 1'b0;
      if (lt1_q && (quot_q < floor_q)) begin
        pend_pos_q <= floor_q;
      end else begin
        pend_pos_q <= quot_q;
      end
    end
    if (cmd_i.load_out) begin
      pos_q  <= pend_pos_q;
      flag_q <= pend_flag_q;
    end
  end

endmodule

FILE: design/ring_position_interpolator_core.sv
// top level of the ring position interpolator
`timescale 1ns / 1ps

// Estimates the play position of an audio ring buffer from the last device
// timestamp. Start, stop and timestamp commands go from accept through the finish
// state into the output register, which is loaded once the output is free. A
// position query that needs arithmetic uses a divider DIV_BITS wide, DIV_BITS
// being the larger of TIME_BITS and 32 + FRAME_BITS: one restoring divider, one
// bit a cycle, runs first for the remainder of the elapsed time by the buffer
// time and then for the scaled remainder divided by the buffer time. One item
// is in flight at a time; the next one is taken while a result waits on the
// output. Configuration writes are always ready and must come while idle.
module ring_position_interpolator_core #(
  parameter int unsigned TIME_BITS  = 63,
  parameter int unsigned FRAME_BITS = 20
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  rpi_in_if.sink     in_i,
  rpi_out_if.source  out_o,
  rpi_cfg_if.sink    cfg_i
);

  rpi_pkg::dp_cmd_t dp_cmd;
  rpi_pkg::dp_sts_t dp_sts;

  logic [TIME_BITS-1:0]  time_ns;
  logic [FRAME_BITS-1:0] position_frames;

  assign cfg_i.ready           = 1'b1;
  assign time_ns               = in_i.time_ns;
  assign out_o.position_frames = position_frames;

  rpi_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .in_cmd_i    (in_i.cmd),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (dp_sts),
    .cmd_o       (dp_cmd)
  );

  rpi_datapath #(
    .TIME_BITS  (TIME_BITS),
    .FRAME_BITS (FRAME_BITS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (dp_cmd),
    .sts_o      (dp_sts),
    .time_i     (time_ns),
    .cfg_we_i   (cfg_i.valid),
    .cfg_idx_i  (cfg_i.index),
    .cfg_data_i (cfg_i.data),
    .position_o (position_frames),
    .period_o   (out_o.period_elapsed)
  );

endmodule
